// File: rtl/core/pdf_pkg.sv
// Package for the packet deframer with 16-bit additive checksum.
// Holds the phase encoding, result kinds, register indexes and shared structs.
// No dependencies.
package pdf_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd2;

    localparam logic [7:0]  RST_DATA_TYPE = 8'd2;
    localparam logic [7:0]  RST_LAST_TYPE = 8'd130;
    localparam logic [15:0] RST_MAX_LEN   = 16'd2048;

    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_CONTROL  = 3'd1;
    localparam logic [2:0] KIND_OK       = 3'd2;
    localparam logic [2:0] KIND_TOO_LONG = 3'd3;
    localparam logic [2:0] KIND_BAD_SUM  = 3'd4;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SEQ     = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_SUM_LO  = 7'b0100000,
        PH_SUM_HI  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_type_code;
        logic [7:0]  last_type_code;
        logic [15:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  data_byte;
        logic        is_last_packet;
        logic [7:0]  sequence_res;
        logic [15:0] packet_length;
        logic [15:0] checksum_sum;
    } t_result;

endpackage

// File: rtl/core/pdf_cfg_regs.sv
// Configuration registers of the packet deframer: type codes and maximum length.
// Depends on pdf_pkg.
module pdf_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pdf_pkg::t_cfg                 o_cfg
);
    import pdf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_type_code <= RST_DATA_TYPE;
            r_cfg.last_type_code <= RST_LAST_TYPE;
            r_cfg.max_length     <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_TYPE: r_cfg.data_type_code <= i_cfg_wdata[7:0];
                CFG_LAST_TYPE: r_cfg.last_type_code <= i_cfg_wdata[7:0];
                CFG_MAX_LEN:   r_cfg.max_length     <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pdf_step.sv
// Deframing state machine: one step per byte, header capture, payload sum, verdict.
// Depends on pdf_pkg.
module pdf_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdf_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output pdf_pkg::t_result o_res
);
    import pdf_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_last, n_last;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_sum_lo, n_sum_lo;

    logic [15:0] len_full;
    logic [15:0] sum_add;
    logic [15:0] count_inc;
    logic [15:0] rx_sum;

    assign len_full  = {i_byte, r_len[7:0]};
    assign sum_add   = r_sum + {8'd0, i_byte};
    assign count_inc = r_count + 16'd1;
    assign rx_sum    = {i_byte, r_sum_lo};

    always_comb begin
        n_phase     = r_phase;
        n_last      = r_last;
        n_seq       = r_seq;
        n_len       = r_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_sum_lo    = r_sum_lo;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_SEQ: begin
                n_seq   = i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = len_full;
                n_sum   = '0;
                n_count = '0;
                if (len_full > i_cfg.max_length) begin
                    o_res_valid          = 1'b1;
                    o_res.result_kind    = KIND_TOO_LONG;
                    o_res.is_last_packet = r_last;
                    o_res.sequence_res   = r_seq;
                    o_res.packet_length  = len_full;
                    n_phase              = PH_IDLE;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_SUM_LO;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum                = sum_add;
                n_count              = count_inc;
                o_res_valid          = 1'b1;
                o_res.result_kind    = KIND_PAYLOAD;
                o_res.data_byte      = i_byte;
                o_res.is_last_packet = r_last;
                o_res.sequence_res   = r_seq;
                o_res.packet_length  = r_len;
                o_res.checksum_sum   = sum_add;
                if (count_inc >= r_len) begin
                    n_phase = PH_SUM_LO;
                end
            end
            PH_SUM_LO: begin
                n_sum_lo = i_byte;
                n_phase  = PH_SUM_HI;
            end
            PH_SUM_HI: begin
                o_res_valid          = 1'b1;
                o_res.result_kind    = (rx_sum == r_sum) ? KIND_OK : KIND_BAD_SUM;
                o_res.is_last_packet = r_last;
                o_res.sequence_res   = r_seq;
                o_res.packet_length  = r_len;
                o_res.checksum_sum   = r_sum;
                n_phase              = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte == i_cfg.data_type_code || i_byte == i_cfg.last_type_code) begin
                    n_last  = (i_byte != i_cfg.data_type_code);
                    n_phase = PH_SEQ;
                end else begin
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_CONTROL;
                    o_res.data_byte   = i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_last   <= 1'b0;
            r_seq    <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_sum_lo <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_sum_lo <= n_sum_lo;
        end
    end

endmodule

// File: rtl/core/pdf_out_reg.sv
// Result register of the packet deframer: holds one result beat until taken.
// Depends on pdf_pkg.
module pdf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pdf_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output pdf_pkg::t_result o_res
);
    import pdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/core/packet_deframer_sum16_top.sv
// Top level of the packet deframer with 16-bit additive checksum.
// Depends on pdf_pkg, pdf_cfg_regs, pdf_step and pdf_out_reg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_stall    | i_rx_byte
//  out      | o_out_valid / i_out_stall  | o_result_kind, o_data_byte, ...
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// One byte per cycle sustained while the output is not stalled; an accepted byte is held
// in the input register, then one state step writes its result, if any, into the result register.
// Reset is synchronous and active low; it restores the register defaults and idle.
// The input stalls only while its register holds a byte and the result register
// is full and stalled.
module packet_deframer_sum16_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_result_kind,
    output logic [7:0]                    o_data_byte,
    output logic                          o_is_last_packet,
    output logic [7:0]                    o_sequence_res,
    output logic [15:0]                   o_packet_length,
    output logic [15:0]                   o_checksum_sum,
    input  logic                          i_cfg_we,
    input  logic [pdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pdf_pkg::*;

    t_cfg       cfg;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;
    logic       in_accept;

    pdf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    pdf_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pdf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_result_kind    = out_res.result_kind;
    assign o_data_byte      = out_res.data_byte;
    assign o_is_last_packet = out_res.is_last_packet;
    assign o_sequence_res   = out_res.sequence_res;
    assign o_packet_length  = out_res.packet_length;
    assign o_checksum_sum   = out_res.checksum_sum;

endmodule

// File: rtl/core/pdf_checker.sv
// Port-level checks for the packet deframer top level, bound in below.
// Depends on pdf_pkg and packet_deframer_sum16_top.
module pdf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [2:0]                    o_result_kind,
    input logic [7:0]                    o_data_byte,
    input logic                          o_is_last_packet,
    input logic [7:0]                    o_sequence_res,
    input logic [15:0]                   o_packet_length,
    input logic [15:0]                   o_checksum_sum
);
    import pdf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result beat");

    a_control_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_CONTROL |->
            !o_is_last_packet && o_sequence_res == 8'd0 && o_packet_length == 16'd0
            && o_checksum_sum == 16'd0)
        else $error("control beat carries packet fields");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_OK || o_result_kind == KIND_BAD_SUM
            || o_result_kind == KIND_TOO_LONG) |-> o_data_byte == 8'd0)
        else $error("verdict beat carries a data byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("beat present after reset");

endmodule

bind packet_deframer_sum16_top pdf_checker u_pdf_checker (.*);
